// ===== design/mlqm_pkg.sv =====
// Shared types and constants for the linked-list multi-queue manager.
// No dependencies; every other design file except mlqm_ram imports this package.
package mlqm_pkg;

  localparam int POOL_SIZE  = 256;
  localparam int NUM_QUEUES = 8;
  localparam int NODE_W     = $clog2(POOL_SIZE);
  localparam int QIDX_W     = $clog2(NUM_QUEUES);
  localparam int CNT_W      = 9;
  localparam int HANDLE_W   = 32;
  localparam int KIND_W     = 2;
  localparam int QID_W      = 3;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [HANDLE_W-1:0] handle_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ_TAIL = 2'd0,
    KIND_ENQ_HEAD = 2'd1,
    KIND_DEQ      = 2'd2,
    KIND_NOP      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_NULL      = 2'd3
  } status_t;

  localparam node_t LAST_NODE = node_t'(POOL_SIZE - 1);
  localparam cnt_t  POOL_CNT  = cnt_t'(POOL_SIZE);

  // One write request into the link store.
  typedef struct packed {
    logic  en;
    node_t addr;
    node_t data;
  } link_wr_t;

endpackage

// ===== design/mlqm_in_if.sv =====
// Request channel of the queue manager: valid/ready plus the operation fields.
// Depends on mlqm_pkg for field widths.
interface mlqm_in_if import mlqm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [QID_W-1:0]    queue_id;
  logic [HANDLE_W-1:0] buffer_handle;

  modport source (output valid, kind, queue_id, buffer_handle, input ready);
  modport sink   (input valid, kind, queue_id, buffer_handle, output ready);
endinterface

// ===== design/mlqm_out_if.sv =====
// Result channel of the queue manager: valid/ready plus handle, status and counts.
// Depends on mlqm_pkg for field widths.
interface mlqm_out_if import mlqm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] out_handle;
  logic [1:0]          status;
  logic [CNT_W-1:0]    queue_count;
  logic [CNT_W-1:0]    free_count;

  modport source (output valid, out_handle, status, queue_count, free_count, input ready);
  modport sink   (input valid, out_handle, status, queue_count, free_count, output ready);
endinterface

// ===== design/mlqm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module mlqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/mlqm_link_store.sv =====
// Node link store: link RAM plus per-node written bits, so an unwritten
// node reads as its successor index. Depends on mlqm_pkg and mlqm_ram.
module mlqm_link_store import mlqm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     rd_en,
  input  node_t    rd_addr,
  output node_t    rd_data,
  input  link_wr_t wr
);

  logic [POOL_SIZE-1:0] written_r;
  logic                 rd_written_r;
  node_t                rd_addr_r;
  node_t                ram_q;
  node_t                succ;

  mlqm_ram #(
    .WIDTH (NODE_W),
    .DEPTH (POOL_SIZE)
  ) u_link_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr.en) begin
      written_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_written_r <= written_r[rd_addr];
      rd_addr_r    <= rd_addr;
    end
  end

  // Reset contents: each node links to the next, the last wraps to zero.
  assign succ    = (rd_addr_r == LAST_NODE) ? '0 : node_t'(rd_addr_r + node_t'(1));
  assign rd_data = rd_written_r ? ram_q : succ;

endmodule

// ===== design/linked_list_multi_queue_manager.sv =====
// Linked-list multi-queue manager: top level with control, queue pointers and counts.
// Depends on mlqm_pkg, mlqm_in_if, mlqm_out_if, mlqm_ram and mlqm_link_store.
//
// Usage:
//   in_ch carries one operation per beat: kind (enqueue at tail, enqueue at
//   head, dequeue, no-op), queue_id and buffer_handle. out_ch returns exactly
//   one result beat per operation: dequeued handle, status, and the counts of
//   the addressed queue and of the free list after the operation.
//   An operation runs in two steps: the accept cycle reads the link and handle
//   memories, and the execute state applies the result and writes them back.
//   The registered read data of those memories makes this split, so the block
//   takes no new operation until the last one has left the execute state.
//   The result is loaded into the output register as the execute state ends.
//   The result sits in an output register; a new operation is accepted while
//   it waits. If the receiver stalls, the next operation holds in its execute
//   state until the waiting result is taken, and in_ch.ready stays low.
//   Reset (rst_n low, synchronous) empties all queues and puts all nodes on
//   the free list in index order; the link memory needs no clearing pass.
module linked_list_multi_queue_manager import mlqm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mlqm_in_if.sink    in_ch,
  mlqm_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  kind_t            op_kind_r;
  logic [QIDX_W-1:0] op_q_r;
  handle_t          op_handle_r;

  node_t queue_head_r [NUM_QUEUES];
  node_t queue_tail_r [NUM_QUEUES];
  cnt_t  queue_size_r [NUM_QUEUES];
  node_t free_head_r, free_head_nxt;
  node_t free_tail_r, free_tail_nxt;
  cnt_t  free_size_r, free_size_nxt;

  node_t head_nxt, tail_nxt;
  cnt_t  size_nxt;

  logic    out_valid_r;
  handle_t out_handle_r, out_handle_nxt;
  status_t out_status_r, out_status_nxt;
  cnt_t    out_qcnt_r;
  cnt_t    out_fcnt_r;

  logic              accept;
  logic              go;
  logic [QIDX_W-1:0] q_in;
  node_t             rd_addr;
  node_t             link_q;
  handle_t           handle_q;
  link_wr_t          link_wr;
  logic              hwr_en;
  node_t             hwr_addr;
  handle_t           hwr_data;
  node_t             cur_head, cur_tail;
  cnt_t              cur_size;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign go          = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);
  assign q_in        = in_ch.queue_id[QIDX_W-1:0];

  // Dequeue reads at the queue head, enqueue at the free-list head.
  assign rd_addr = (kind_t'(in_ch.kind) == KIND_DEQ) ? queue_head_r[q_in] : free_head_r;

  mlqm_link_store u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (link_q),
    .wr      (link_wr)
  );

  mlqm_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (POOL_SIZE)
  ) u_handle_ram (
    .clk   (clk),
    .we    (hwr_en),
    .waddr (hwr_addr),
    .wdata (hwr_data),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (handle_q)
  );

  assign cur_head = queue_head_r[op_q_r];
  assign cur_tail = queue_tail_r[op_q_r];
  assign cur_size = queue_size_r[op_q_r];

  always_comb begin
    head_nxt       = cur_head;
    tail_nxt       = cur_tail;
    size_nxt       = cur_size;
    free_head_nxt  = free_head_r;
    free_tail_nxt  = free_tail_r;
    free_size_nxt  = free_size_r;
    out_handle_nxt = '0;
    out_status_nxt = ST_OK;
    link_wr        = '0;
    hwr_en         = 1'b0;
    hwr_addr       = free_head_r;
    hwr_data       = op_handle_r;
    unique case (op_kind_r)
      KIND_ENQ_TAIL, KIND_ENQ_HEAD: begin
        if (op_handle_r == '0) begin
          out_status_nxt = ST_NULL;
        end else if (free_size_r == '0) begin
          out_status_nxt = ST_EXHAUSTED;
        end else begin
          free_head_nxt = link_q;
          free_size_nxt = cnt_t'(free_size_r - cnt_t'(1));
          hwr_en        = 1'b1;
          size_nxt      = cnt_t'(cur_size + cnt_t'(1));
          if (cur_size == '0) begin
            head_nxt = free_head_r;
            tail_nxt = free_head_r;
          end else if (op_kind_r == KIND_ENQ_TAIL) begin
            link_wr  = '{en: 1'b1, addr: cur_tail, data: free_head_r};
            tail_nxt = free_head_r;
          end else begin
            link_wr  = '{en: 1'b1, addr: free_head_r, data: cur_head};
            head_nxt = free_head_r;
          end
        end
      end
      KIND_DEQ: begin
        if (cur_size == '0) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          out_handle_nxt = handle_q;
          head_nxt       = link_q;
          size_nxt       = cnt_t'(cur_size - cnt_t'(1));
          hwr_en         = 1'b1;
          hwr_addr       = cur_head;
          hwr_data       = '0;
          // Released node goes to the free-list tail, or starts the list.
          if (free_size_r == '0) begin
            free_head_nxt = cur_head;
          end else begin
            link_wr = '{en: 1'b1, addr: free_tail_r, data: cur_head};
          end
          free_tail_nxt = cur_head;
          free_size_nxt = cnt_t'(free_size_r + cnt_t'(1));
        end
      end
      KIND_NOP: begin
      end
      default: begin
      end
    endcase
    if (!go) begin
      link_wr.en = 1'b0;
      hwr_en     = 1'b0;
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = go ? S_IDLE : S_EXEC;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      free_head_r <= '0;
      free_tail_r <= LAST_NODE;
      free_size_r <= POOL_CNT;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        queue_size_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (go) begin
        out_valid_r          <= 1'b1;
        free_head_r          <= free_head_nxt;
        free_tail_r          <= free_tail_nxt;
        free_size_r          <= free_size_nxt;
        queue_size_r[op_q_r] <= size_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind_r   <= kind_t'(in_ch.kind);
      op_q_r      <= q_in;
      op_handle_r <= in_ch.buffer_handle;
    end
    if (go) begin
      queue_head_r[op_q_r] <= head_nxt;
      queue_tail_r[op_q_r] <= tail_nxt;
      out_handle_r         <= out_handle_nxt;
      out_status_r         <= out_status_nxt;
      out_qcnt_r           <= size_nxt;
      out_fcnt_r           <= free_size_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_handle  = out_handle_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.queue_count = out_qcnt_r;
  assign out_ch.free_count  = out_fcnt_r;

endmodule

// ===== design/mlqm_checker.sv =====
// Port-level checks for the queue manager, bound to the top level.
// Depends on mlqm_pkg for status codes.
module mlqm_checker import mlqm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [HANDLE_W-1:0] out_handle,
  input logic [1:0]       status,
  input logic [CNT_W-1:0] queue_count,
  input logic [CNT_W-1:0] free_count
);

  // Hold a result beat until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Take one operation at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second operation accepted while one is in progress");

  // A result is loaded only from the execute step of an operation, while in_ready is low.
  a_result_follows_op: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an operation in progress");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |-> out_handle == '0 && queue_count == '0)
    else $error("empty-queue result carries a handle or a nonzero count");

  a_exhausted_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EXHAUSTED |-> out_handle == '0 && free_count == '0)
    else $error("pool-exhausted result with free nodes left");

endmodule

bind linked_list_multi_queue_manager mlqm_checker u_mlqm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_handle  (out_ch.out_handle),
  .status      (out_ch.status),
  .queue_count (out_ch.queue_count),
  .free_count  (out_ch.free_count)
);
